// File: design/fat_cluster_table_engine_top_macros.svh
// Assertion helpers for the cluster table engine.
`ifndef FAT_CLUSTER_TABLE_ENGINE_TOP_MACROS_SVH
`define FAT_CLUSTER_TABLE_ENGINE_TOP_MACROS_SVH

// Generic clocked assertion with an active-low reset.
`define FCTE_ASSERT(lbl, ck, rst_n, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) prop) else $error(msg);

// Same, on the block's own clock and reset.
`define FCTE_CHK(lbl, prop, msg) \
	`FCTE_ASSERT(lbl, clk, arst_n, prop, msg)

`endif

// File: design/fcte_pkg.sv
package fcte_pkg;

	localparam int TABLE_DEPTH_DEF = 4096;

	localparam int FUNC_W    = 3;
	localparam int CLUSTER_W = 12;
	localparam int ENTRY_W   = 32;
	localparam int RESULT_W  = 28;
	localparam int STATUS_W  = 2;
	localparam int COUNT_W   = 12;

	// wide enough for any chain link plus the table depth
	localparam int CMP_W = 29;

	localparam logic [FUNC_W-1:0] FN_READ  = 3'd0;
	localparam logic [FUNC_W-1:0] FN_WRITE = 3'd1;
	localparam logic [FUNC_W-1:0] FN_ALLOC = 3'd2;
	localparam logic [FUNC_W-1:0] FN_FREE  = 3'd3;
	localparam logic [FUNC_W-1:0] FN_LOAD  = 3'd4;

	localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_NOSPACE = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_RANGE   = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_LONG    = 2'd3;

	localparam logic [RESULT_W-1:0] LOW28      = 28'hFFF_FFFF;
	localparam logic [CMP_W-1:0]    EOC_MIN    = 29'h0FFF_FFF8;
	localparam logic [CMP_W-1:0]    FIRST_DATA = 29'd2;

	localparam logic [0:0] REG_CLUSTER_COUNT = 1'b0;

	typedef logic [FUNC_W-1:0]    func_t;
	typedef logic [CLUSTER_W-1:0] cluster_t;
	typedef logic [ENTRY_W-1:0]   entry_t;
	typedef logic [RESULT_W-1:0]  result_t;
	typedef logic [STATUS_W-1:0]  status_t;

endpackage

// File: design/fcte_req_if.sv
interface fcte_req_if;
	import fcte_pkg::*;

	logic     valid;
	logic     ready;
	func_t    func;
	cluster_t cluster;
	entry_t   entry_value;

	modport source (output valid, output func, output cluster, output entry_value, input ready);
	modport sink (input valid, input func, input cluster, input entry_value, output ready);
endinterface

// File: design/fcte_rsp_if.sv
interface fcte_rsp_if;
	import fcte_pkg::*;

	logic    valid;
	logic    ready;
	result_t result_value;
	status_t status;

	modport source (output valid, output result_value, output status, input ready);
	modport sink (input valid, input result_value, input status, output ready);
endinterface

// File: design/fat_cluster_table_engine_top.sv
// channel  dir  handshake      payload
// req      in   valid/ready    func, cluster, entry_value
// rsp      out  valid/ready    result_value, status
// apb      in   psel/penable   paddr, pwdata -> cluster_count; pready tied high
//
// Read/write: accept, table read, result. Load, range errors, no-op free: accept, result.
// Allocate: accept, a scan step per entry scanned, result; free chain: accept, a walk
// step per link cleared, result. One table memory, one registered entry read per cycle.
// A request is taken only while no other request is in flight; a finished result
// waits in the output register while rsp is stalled and the next request is taken.
// Reset clears control state and cluster_count; table contents are undefined until loaded.
module fat_cluster_table_engine_top #(
	parameter int TABLE_DEPTH = fcte_pkg::TABLE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	fcte_req_if.sink    req,
	fcte_rsp_if.source  rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import fcte_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam logic [CMP_W-1:0] DEPTH_W = CMP_W'(TABLE_DEPTH);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD   = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_WALK = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;

	logic [2:0]         state_q, state_d;
	func_t              func_q, func_d;
	result_t            val_q, val_d;
	logic [AW-1:0]      cur_q, cur_d;
	logic [AW:0]        steps_q, steps_d, steps_nx;
	result_t            res_q, res_d;
	status_t            st_q, st_d;
	logic               out_valid_q, out_valid_d;
	result_t            out_res_q, out_res_d;
	status_t            out_st_q, out_st_d;
	logic [COUNT_W-1:0] cnt_q;

	entry_t             table_mem [TABLE_DEPTH];
	entry_t             mem_rd_q, fwd_data_q, rd_data;
	logic               fwd_q;
	logic               we;
	logic [AW-1:0]      wa, ra;
	entry_t             wd;

	logic               acc, cl_in, cfg_wr;
	logic [CMP_W-1:0]   cl29, lim29, cur29, cur_nx29, nxt29, sum29;
	logic [AW-1:0]      cl_idx;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_CLUSTER_COUNT) ? {20'd0, cnt_q} : 32'd0;

	assign req.ready        = (state_q == S_IDLE);
	assign rsp.valid        = out_valid_q;
	assign rsp.result_value = out_res_q;
	assign rsp.status       = out_st_q;

	assign acc      = req.valid && req.ready;
	assign cl29     = CMP_W'(req.cluster);
	assign cl_in    = cl29 < DEPTH_W;
	assign cl_idx   = cl29[AW-1:0];
	assign rd_data  = fwd_q ? fwd_data_q : mem_rd_q;
	assign sum29    = CMP_W'(cnt_q) + FIRST_DATA;
	assign lim29    = (sum29 > DEPTH_W) ? DEPTH_W : sum29;
	assign cur29    = CMP_W'(cur_q);
	assign cur_nx29 = cur29 + CMP_W'(1);
	assign nxt29    = {1'b0, rd_data[RESULT_W-1:0]};
	assign steps_nx = steps_q + (AW+1)'(1);

	always_comb begin
		state_d     = state_q;
		func_d      = func_q;
		val_d       = val_q;
		cur_d       = cur_q;
		steps_d     = steps_q;
		res_d       = res_q;
		st_d        = st_q;
		out_valid_d = out_valid_q && !rsp.ready;
		out_res_d   = out_res_q;
		out_st_d    = out_st_q;
		we          = 1'b0;
		wa          = cur_q;
		wd          = rd_data;
		ra          = cur_q;
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					func_d  = req.func;
					val_d   = req.entry_value[RESULT_W-1:0];
					res_d   = '0;
					st_d    = STAT_OK;
					state_d = S_FIN;
					unique case (req.func) inside
						FN_READ, FN_WRITE: begin
							if (cl_in) begin
								ra      = cl_idx;
								cur_d   = cl_idx;
								state_d = S_RD;
							end else begin
								st_d = STAT_RANGE;
							end
						end
						FN_LOAD: begin
							if (cl_in) begin
								we = 1'b1;
								wa = cl_idx;
								wd = req.entry_value;
							end else begin
								st_d = STAT_RANGE;
							end
						end
						FN_ALLOC: begin
							cur_d = FIRST_DATA[AW-1:0];
							if (FIRST_DATA < lim29) begin
								ra      = FIRST_DATA[AW-1:0];
								state_d = S_SCAN;
							end else begin
								st_d = STAT_NOSPACE;
							end
						end
						FN_FREE: begin
							// a start below the first data cluster is a no-op
							if (cl29 >= FIRST_DATA) begin
								if (!cl_in) begin
									st_d = STAT_RANGE;
								end else begin
									ra      = cl_idx;
									cur_d   = cl_idx;
									steps_d = '0;
									state_d = S_WALK;
								end
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_RD: begin
				if (func_q == FN_READ) begin
					res_d = rd_data[RESULT_W-1:0];
				end else begin
					we = 1'b1;
					wd = {rd_data[ENTRY_W-1:RESULT_W], val_q};
				end
				state_d = S_FIN;
			end
			S_SCAN: begin
				if (rd_data[RESULT_W-1:0] == '0) begin
					we      = 1'b1;
					wd      = {rd_data[ENTRY_W-1:RESULT_W], LOW28};
					res_d   = cur29[RESULT_W-1:0];
					state_d = S_FIN;
				end else if (cur_nx29 < lim29) begin
					ra    = cur_nx29[AW-1:0];
					cur_d = cur_nx29[AW-1:0];
				end else begin
					st_d    = STAT_NOSPACE;
					state_d = S_FIN;
				end
			end
			S_WALK: begin
				we      = 1'b1;
				wd      = {rd_data[ENTRY_W-1:RESULT_W], {RESULT_W{1'b0}}};
				steps_d = steps_nx;
				if (nxt29 < FIRST_DATA || nxt29 >= EOC_MIN) begin
					state_d = S_FIN;
				end else if (nxt29 >= DEPTH_W) begin
					st_d    = STAT_RANGE;
					state_d = S_FIN;
				end else if (CMP_W'(steps_nx) >= DEPTH_W) begin
					st_d    = STAT_LONG;
					state_d = S_FIN;
				end else begin
					// next link may be the entry written now; forwarding covers it
					ra    = nxt29[AW-1:0];
					cur_d = nxt29[AW-1:0];
				end
			end
			S_FIN: begin
				if (!out_valid_q || rsp.ready) begin
					out_valid_d = 1'b1;
					out_res_d   = res_q;
					out_st_d    = st_q;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			table_mem[wa] <= wd;
		end
		mem_rd_q   <= table_mem[ra];
		fwd_q      <= we && (wa == ra);
		fwd_data_q <= wd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
			if (cfg_wr && paddr[2] == REG_CLUSTER_COUNT) begin
				cnt_q <= pwdata[COUNT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		func_q    <= func_d;
		val_q     <= val_d;
		cur_q     <= cur_d;
		steps_q   <= steps_d;
		res_q     <= res_d;
		st_q      <= st_d;
		out_res_q <= out_res_d;
		out_st_q  <= out_st_d;
	end

endmodule

// File: design/fcte_checker.sv
`include "fat_cluster_table_engine_top_macros.svh"

module fcte_props (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input fcte_pkg::result_t rsp_value,
	input fcte_pkg::status_t rsp_status
);
	import fcte_pkg::*;

	logic [RESULT_W+STATUS_W-1:0] rsp_payload;

	assign rsp_payload = {rsp_value, rsp_status};

	`FCTE_CHK(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "result dropped while stalled")
	`FCTE_CHK(a_rsp_stable, rsp_valid && !rsp_ready |=> $stable(rsp_payload), "payload moved")
	`FCTE_CHK(a_one_in_flight, req_valid && req_ready |=> !req_ready, "request taken while busy")
	`FCTE_CHK(a_err_zero, rsp_valid && rsp_status != STAT_OK |-> rsp_value == '0, "value on error")

endmodule

bind fat_cluster_table_engine_top fcte_props u_fcte_props (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_value  (rsp.result_value),
	.rsp_status (rsp.status)
);
